// File: rtl/core/saic_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lamp helpers of the intersection controller.
package saic_pkg;

  localparam int TIMER_BITS_DEFAULT = 8;
  localparam int CFG_WIDTH = 8;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int LAMP_WIDTH = 24;
  localparam int DEMAND_WIDTH = 4;

  localparam logic [CFG_WIDTH-1:0] RIGHT_LIMIT_RESET = 8'd5;
  localparam logic [CFG_WIDTH-1:0] STRAIGHT_LIMIT_RESET = 8'd5;
  localparam logic [CFG_WIDTH-1:0] YELLOW_TICKS_RESET = 8'd1;
  localparam logic [7:0] PICKER_SEED = 8'h5A;

  // Lamp groups; a straight lane adds 0 to its group, a right-turn lane adds 1.
  localparam logic [2:0] G_RED = 3'd0;
  localparam logic [2:0] G_YELLOW = 3'd2;
  localparam logic [2:0] G_GREEN = 3'd4;

  // All straight and right-turn reds lit.
  localparam logic [LAMP_WIDTH-1:0] LAMP_RESET = 24'h0000FF;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_RIGHT_LIMIT = 2'd0,
    CFG_STRAIGHT_LIMIT = 2'd1,
    CFG_YELLOW_TICKS = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    MODE_DISPATCH = 3'd0,
    MODE_IDLE_YELLOW = 3'd1,
    MODE_RIGHT = 3'd2,
    MODE_STRAIGHT = 3'd3
  } mode_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] right_limit;
    logic [CFG_WIDTH-1:0] straight_limit;
    logic [CFG_WIDTH-1:0] yellow_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    logic pair;
    logic pending;
    logic [1:0] carried;
    logic [1:0] idle_side;
    logic idle_on;
    logic [7:0] picker;
    logic [LAMP_WIDTH-1:0] lamp;
  } ctrl_t;

  // Lamp of group g and side s sits at bit 4*g+s, which is just {g, s}.
  function automatic logic [LAMP_WIDTH-1:0] put_lamp(logic [LAMP_WIDTH-1:0] v,
                                                     logic [2:0] g, logic [1:0] s,
                                                     logic on);
    logic [LAMP_WIDTH-1:0] r;
    r = v;
    r[{g, s}] = on;
    return r;
  endfunction

  function automatic logic [LAMP_WIDTH-1:0] shift_lane(logic [LAMP_WIDTH-1:0] v,
                                                       logic t, logic [1:0] s,
                                                       logic [2:0] from_g,
                                                       logic [2:0] to_g);
    logic [LAMP_WIDTH-1:0] r;
    r = put_lamp(v, from_g + {2'b00, t}, s, 1'b0);
    r = put_lamp(r, to_g + {2'b00, t}, s, 1'b1);
    return r;
  endfunction

  function automatic logic lamp_on(logic [LAMP_WIDTH-1:0] v, logic [2:0] g, logic [1:0] s);
    return v[{g, s}];
  endfunction

  function automatic logic lane_red(logic [LAMP_WIDTH-1:0] v, logic t, logic [1:0] s);
    return !v[{G_GREEN + {2'b00, t}, s}] && !v[{G_YELLOW + {2'b00, t}, s}];
  endfunction

  function automatic logic pair_demand(logic pair, logic [DEMAND_WIDTH-1:0] sd,
                                       logic [DEMAND_WIDTH-1:0] rd);
    logic [DEMAND_WIDTH-1:0] any;
    any = sd | rd;
    return pair ? |any[3:2] : |any[1:0];
  endfunction

  // Opens the green of every lane of the served pair whose sensor is set.
  function automatic logic [LAMP_WIDTH-1:0] open_phase(logic [LAMP_WIDTH-1:0] v, logic t,
                                                       logic pair,
                                                       logic [DEMAND_WIDTH-1:0] d);
    logic [LAMP_WIDTH-1:0] r;
    r = v;
    if (d[{pair, 1'b0}]) r = shift_lane(r, t, {pair, 1'b0}, G_RED, G_GREEN);
    if (d[{pair, 1'b1}]) r = shift_lane(r, t, {pair, 1'b1}, G_RED, G_GREEN);
    return r;
  endfunction

  function automatic logic phase_lit(logic [LAMP_WIDTH-1:0] v, logic t, logic pair);
    return !(lane_red(v, t, {pair, 1'b0}) && lane_red(v, t, {pair, 1'b1}));
  endfunction

  // x^8 + x^6 + x^5 + x^4 + 1
  function automatic logic [7:0] picker_step(logic [7:0] p);
    return {p[6:0], p[7] ^ p[5] ^ p[4] ^ p[3]};
  endfunction

endpackage

// File: rtl/core/saic_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: green limits and yellow time.
module saic_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 we,
  input  logic [saic_pkg::CFG_INDEX_WIDTH-1:0] index,
  input  logic [saic_pkg::CFG_WIDTH-1:0]       wdata,
  output saic_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right_limit <= saic_pkg::RIGHT_LIMIT_RESET;
      cfg.straight_limit <= saic_pkg::STRAIGHT_LIMIT_RESET;
      cfg.yellow_ticks <= saic_pkg::YELLOW_TICKS_RESET;
    end else if (we) begin
      case (index)
        saic_pkg::CFG_RIGHT_LIMIT: cfg.right_limit <= wdata;
        saic_pkg::CFG_STRAIGHT_LIMIT: cfg.straight_limit <= wdata;
        saic_pkg::CFG_YELLOW_TICKS: cfg.yellow_ticks <= wdata;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/saic_step.sv
`timescale 1ns / 1ps
// Next-state logic for one tick: dispatch, idle yellow and the phase sequencer.
module saic_step #(
  parameter int TIMER_BITS = saic_pkg::TIMER_BITS_DEFAULT
) (
  input  saic_pkg::ctrl_t                       cur,
  input  logic [TIMER_BITS-1:0]                 phase_elapsed,
  input  logic [1:0][TIMER_BITS-1:0]            yel_elapsed,
  input  saic_pkg::cfg_t                        cfg,
  input  logic [saic_pkg::DEMAND_WIDTH-1:0]     sd,
  input  logic [saic_pkg::DEMAND_WIDTH-1:0]     rd,
  output saic_pkg::ctrl_t                       nxt,
  output logic [TIMER_BITS-1:0]                 phase_elapsed_next,
  output logic [1:0][TIMER_BITS-1:0]            yel_elapsed_next
);

  localparam int CW = (TIMER_BITS > saic_pkg::CFG_WIDTH) ? TIMER_BITS : saic_pkg::CFG_WIDTH;

  function automatic logic [TIMER_BITS-1:0] sat_inc(logic [TIMER_BITS-1:0] e);
    return (e == '1) ? e : e + TIMER_BITS'(1);
  endfunction

  // A saturated count always counts as expired.
  function automatic logic expired(logic [TIMER_BITS-1:0] e,
                                   logic [saic_pkg::CFG_WIDTH-1:0] lim);
    return (CW'(e) >= CW'(lim)) || (e == '1);
  endfunction

  always_comb begin
    saic_pkg::ctrl_t n;
    logic [TIMER_BITS-1:0] pe;
    logic [1:0][TIMER_BITS-1:0] ye;
    logic t;
    logic [saic_pkg::DEMAND_WIDTH-1:0] d;
    logic [saic_pkg::CFG_WIDTH-1:0] lim;
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] side;
    logic [2:0] cnt;
    logic chain;

    n = cur;
    pe = phase_elapsed;
    ye = yel_elapsed;
    chain = 1'b0;
    t = (cur.mode == saic_pkg::MODE_RIGHT);
    d = t ? rd : sd;
    lim = t ? cfg.right_limit : cfg.straight_limit;
    a = {cur.pair, 1'b0};
    b = {cur.pair, 1'b1};
    cnt = 3'($countones(sd | rd));

    case (cur.mode)
      saic_pkg::MODE_RIGHT, saic_pkg::MODE_STRAIGHT: begin
        pe = sat_inc(pe);
        for (int l = 0; l < 2; l++) begin
          side = {cur.pair, 1'(l)};
          if (saic_pkg::lamp_on(n.lamp, saic_pkg::G_YELLOW + {2'b00, t}, side))
            ye[l] = sat_inc(ye[l]);
        end
        for (int l = 0; l < 2; l++) begin
          side = {cur.pair, 1'(l)};
          if (saic_pkg::lamp_on(n.lamp, saic_pkg::G_GREEN + {2'b00, t}, side) &&
              (!d[side] || expired(pe, lim))) begin
            n.lamp = saic_pkg::shift_lane(n.lamp, t, side, saic_pkg::G_GREEN,
                                          saic_pkg::G_YELLOW);
            ye[l] = '0;
          end
        end
        for (int l = 0; l < 2; l++) begin
          side = {cur.pair, 1'(l)};
          if (saic_pkg::lamp_on(n.lamp, saic_pkg::G_YELLOW + {2'b00, t}, side) &&
              expired(ye[l], cfg.yellow_ticks))
            n.lamp = saic_pkg::shift_lane(n.lamp, t, side, saic_pkg::G_YELLOW,
                                          saic_pkg::G_RED);
        end
        // During the right-turn phase a straight lane may open once the
        // opposite side's right-turn lane has gone red.
        if (t) begin
          if (saic_pkg::lane_red(n.lamp, 1'b1, b) && !n.carried[0] && sd[a]) begin
            n.carried[0] = 1'b1;
            n.lamp = saic_pkg::shift_lane(n.lamp, 1'b0, a, saic_pkg::G_RED, saic_pkg::G_GREEN);
          end
          if (saic_pkg::lane_red(n.lamp, 1'b1, a) && !n.carried[1] && sd[b]) begin
            n.carried[1] = 1'b1;
            n.lamp = saic_pkg::shift_lane(n.lamp, 1'b0, b, saic_pkg::G_RED, saic_pkg::G_GREEN);
          end
        end
        if (saic_pkg::lane_red(n.lamp, t, a) && saic_pkg::lane_red(n.lamp, t, b))
          chain = 1'b1;
      end
      saic_pkg::MODE_IDLE_YELLOW: begin
        pe = sat_inc(pe);
        if (expired(pe, cfg.yellow_ticks)) begin
          n.lamp = saic_pkg::shift_lane(n.lamp, 1'b0, cur.idle_side, saic_pkg::G_YELLOW,
                                        saic_pkg::G_RED);
          n.idle_on = 1'b0;
          n.picker = saic_pkg::picker_step(cur.picker);
          n.idle_side = n.picker[1:0];
          n.mode = saic_pkg::MODE_DISPATCH;
        end
      end
      default: begin
        if (cnt == 3'd0) begin
          if (!cur.idle_on) begin
            n.lamp = saic_pkg::shift_lane(n.lamp, 1'b0, cur.idle_side, saic_pkg::G_RED,
                                          saic_pkg::G_GREEN);
            n.idle_on = 1'b1;
          end
        end else if (cur.idle_on) begin
          n.lamp = saic_pkg::shift_lane(n.lamp, 1'b0, cur.idle_side, saic_pkg::G_GREEN,
                                        saic_pkg::G_YELLOW);
          pe = '0;
          n.mode = saic_pkg::MODE_IDLE_YELLOW;
        end else begin
          if (cnt >= 3'd3) begin
            n.pending = 1'b1;
          end else if (saic_pkg::pair_demand(cur.pair, sd, rd)) begin
            n.pending = 1'b1;
          end else begin
            n.pair = ~cur.pair;
            n.pending = 1'b0;
          end
          n.carried = 2'b00;
          n.mode = saic_pkg::MODE_RIGHT;
          pe = '0;
          n.lamp = saic_pkg::open_phase(n.lamp, 1'b1, n.pair, rd);
          if (!saic_pkg::phase_lit(n.lamp, 1'b1, n.pair)) chain = 1'b1;
        end
      end
    endcase

    // A phase that lights nothing ends at once and hands over in the same tick.
    for (int k = 0; k < 4; k++) begin
      if (chain) begin
        if (n.mode == saic_pkg::MODE_RIGHT) begin
          n.mode = saic_pkg::MODE_STRAIGHT;
          pe = '0;
          n.lamp = saic_pkg::open_phase(n.lamp, 1'b0, n.pair, sd);
          if (saic_pkg::phase_lit(n.lamp, 1'b0, n.pair)) chain = 1'b0;
        end else if (n.mode == saic_pkg::MODE_STRAIGHT) begin
          n.carried = 2'b00;
          n.pair = ~n.pair;
          if (n.pending && saic_pkg::pair_demand(n.pair, sd, rd)) begin
            n.pending = 1'b0;
            n.mode = saic_pkg::MODE_RIGHT;
            pe = '0;
            n.lamp = saic_pkg::open_phase(n.lamp, 1'b1, n.pair, rd);
            if (saic_pkg::phase_lit(n.lamp, 1'b1, n.pair)) chain = 1'b0;
          end else begin
            n.pending = 1'b0;
            n.mode = saic_pkg::MODE_DISPATCH;
            chain = 1'b0;
          end
        end else begin
          chain = 1'b0;
        end
      end
    end

    nxt = n;
    phase_elapsed_next = pe;
    yel_elapsed_next = ye;
  end

endmodule

// File: rtl/core/sensor_actuated_intersection_controller_core.sv
`timescale 1ns / 1ps
// Top level of the actuated four-way intersection controller.
//
// Each input beat is one time tick carrying the straight and right-turn demand
// sensors of the four sides; each output beat carries the 24 lamp bits as they
// stand after that tick. While the output is taken, the block takes one beat per
// clock cycle: a beat is caught in an input register, the controller state
// advances in one pass of next-state logic, and the lamps land in an output
// register. While a finished result waits on the output side, the input
// register holds one more tick and then stalls the input until the result is
// taken. Phase and yellow counters are TIMER_BITS wide and saturate. The user
// writes configuration through the cfg port only while no tick is in flight;
// the block itself does not enforce this. No clearing pass is needed after
// reset.
module sensor_actuated_intersection_controller_core #(
  parameter int TIMER_BITS = saic_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [3:0] straight_demand, [7:4] right_demand
  input  logic [7:0]                           s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [3:0] red_straight, [7:4] red_turn, [11:8] yellow_straight,
  // [15:12] yellow_turn, [19:16] green_straight, [23:20] green_turn
  output logic [23:0]                          m_axis_tdata,
  input  logic                                 cfg_we,
  input  logic [saic_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [saic_pkg::CFG_WIDTH-1:0]       cfg_wdata
);

  saic_pkg::cfg_t cfg;
  saic_pkg::ctrl_t ctrl;
  saic_pkg::ctrl_t ctrl_next;
  logic [TIMER_BITS-1:0] phase_elapsed;
  logic [TIMER_BITS-1:0] phase_elapsed_next;
  logic [1:0][TIMER_BITS-1:0] yel_elapsed;
  logic [1:0][TIMER_BITS-1:0] yel_elapsed_next;

  logic in_valid;
  logic [saic_pkg::DEMAND_WIDTH-1:0] in_sd;
  logic [saic_pkg::DEMAND_WIDTH-1:0] in_rd;
  logic out_valid;
  logic [saic_pkg::LAMP_WIDTH-1:0] out_lamp;
  logic advance;
  logic in_take;

  saic_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  saic_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cur                (ctrl),
    .phase_elapsed      (phase_elapsed),
    .yel_elapsed        (yel_elapsed),
    .cfg                (cfg),
    .sd                 (in_sd),
    .rd                 (in_rd),
    .nxt                (ctrl_next),
    .phase_elapsed_next (phase_elapsed_next),
    .yel_elapsed_next   (yel_elapsed_next)
  );

  assign advance = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign in_take = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_lamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
      ctrl.mode <= saic_pkg::MODE_DISPATCH;
      ctrl.pair <= 1'b0;
      ctrl.pending <= 1'b0;
      ctrl.carried <= 2'b00;
      ctrl.idle_side <= 2'b00;
      ctrl.idle_on <= 1'b0;
      ctrl.picker <= saic_pkg::PICKER_SEED;
      ctrl.lamp <= saic_pkg::LAMP_RESET;
      phase_elapsed <= '0;
      yel_elapsed <= '0;
    end else begin
      if (in_take) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        ctrl <= ctrl_next;
        phase_elapsed <= phase_elapsed_next;
        yel_elapsed <= yel_elapsed_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_sd <= s_axis_tdata[3:0];
      in_rd <= s_axis_tdata[7:4];
    end
    if (advance) begin
      out_lamp <= ctrl_next.lamp;
    end
  end

`ifndef SYNTHESIS
  // Every straight lane shows exactly one of red, yellow and green.
  a_straight_one_lamp: assert property (@(posedge clk) disable iff (rst)
    ((ctrl.lamp[3:0] | ctrl.lamp[11:8] | ctrl.lamp[19:16]) == 4'hF) &&
    ((ctrl.lamp[3:0] & ctrl.lamp[11:8]) == 4'h0) &&
    ((ctrl.lamp[3:0] & ctrl.lamp[19:16]) == 4'h0) &&
    ((ctrl.lamp[11:8] & ctrl.lamp[19:16]) == 4'h0))
    else $error("straight lane lamps inconsistent");

  // Every right-turn lane shows exactly one of red, yellow and green.
  a_right_one_lamp: assert property (@(posedge clk) disable iff (rst)
    ((ctrl.lamp[7:4] | ctrl.lamp[15:12] | ctrl.lamp[23:20]) == 4'hF) &&
    ((ctrl.lamp[7:4] & ctrl.lamp[15:12]) == 4'h0) &&
    ((ctrl.lamp[7:4] & ctrl.lamp[23:20]) == 4'h0) &&
    ((ctrl.lamp[15:12] & ctrl.lamp[23:20]) == 4'h0))
    else $error("right-turn lane lamps inconsistent");

  // Outside the phase sequencer all right-turn lanes are red.
  a_right_red_when_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.mode == saic_pkg::MODE_DISPATCH || ctrl.mode == saic_pkg::MODE_IDLE_YELLOW)
    |-> (ctrl.lamp[7:4] == 4'hF))
    else $error("right-turn lamp lit outside a phase");

  // The side picker can never fall into the all-zero lock-up state.
  a_picker_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctrl.picker != 8'h00)
    else $error("side picker reached zero");

  // A tick that leaves the input register shows up as the next result beat.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> (m_axis_tvalid && m_axis_tdata == ctrl.lamp))
    else $error("result beat does not match controller lamps");
`endif

endmodule

// File: tb/sensor_actuated_intersection_controller_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench: drives demand ticks, predicts every lamp beat and compares it.
module sensor_actuated_intersection_controller_core_tb;

  localparam int TIMER_MAX = (1 << saic_pkg::TIMER_BITS_DEFAULT) - 1;
  localparam logic [saic_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [saic_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = saic_pkg::CFG_RIGHT_LIMIT;
  logic [saic_pkg::CFG_WIDTH-1:0] cfg_wdata = '0;

  sensor_actuated_intersection_controller_core dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Demand beats waiting to be sent ({right_demand, straight_demand}) and lamp words expected.
  logic [7:0] demand_q[$];
  logic [23:0] lamp_expect[$];
  int beats_queued = 0;
  int beats_taken = 0;
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit beat_taken = 1'b0;

  string lamp_field[6] = '{"red_straight", "red_turn", "yellow_straight",
                           "yellow_turn", "green_straight", "green_turn"};

  // Predictor copy of the controller.
  logic [7:0] lim_right = saic_pkg::RIGHT_LIMIT_RESET;
  logic [7:0] lim_straight = saic_pkg::STRAIGHT_LIMIT_RESET;
  logic [7:0] lim_yellow = saic_pkg::YELLOW_TICKS_RESET;
  saic_pkg::mode_t ctl_mode = saic_pkg::MODE_DISPATCH;
  logic pair_sel = 1'b0;
  logic second_pair_due = 1'b0;
  logic [23:0] lamps = saic_pkg::LAMP_RESET;
  logic [7:0] phase_cnt = 8'd0;
  logic [7:0] yel_cnt[2] = '{8'd0, 8'd0};
  logic [1:0] early_straight = 2'b00;
  logic [1:0] rest_side = 2'd0;
  logic rest_green = 1'b0;
  logic [7:0] picker = saic_pkg::PICKER_SEED;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit lamp_lit(int grp, int side);
    return lamps[4 * grp + side];
  endfunction

  function automatic void set_lamp(int grp, int side, bit on);
    lamps[4 * grp + side] = on;
  endfunction

  // t is 0 for a straight lane and 1 for a right-turn lane.
  function automatic void move_lane(int t, int side, int from_grp, int to_grp);
    set_lamp(from_grp + t, side, 1'b0);
    set_lamp(to_grp + t, side, 1'b1);
  endfunction

  function automatic bit lane_is_red(int t, int side);
    return !lamp_lit(saic_pkg::G_GREEN + t, side) && !lamp_lit(saic_pkg::G_YELLOW + t, side);
  endfunction

  function automatic logic [7:0] bump(logic [7:0] v);
    return (int'(v) >= TIMER_MAX) ? v : v + 8'd1;
  endfunction

  function automatic bit timed_out(logic [7:0] e, logic [7:0] lim);
    return (e >= lim) || (int'(e) >= TIMER_MAX);
  endfunction

  function automatic bit pair_wants(logic pair, logic [3:0] sd, logic [3:0] rd);
    logic [3:0] any;
    any = sd | rd;
    return pair ? |any[3:2] : |any[1:0];
  endfunction

  // Starts a phase on the served pair and tells whether any of its lanes is lit.
  function automatic bit open_phase(saic_pkg::mode_t m, logic [3:0] sd, logic [3:0] rd);
    int t;
    int a;
    logic [3:0] d;
    t = (m == saic_pkg::MODE_RIGHT) ? 1 : 0;
    d = t ? rd : sd;
    a = pair_sel ? 2 : 0;
    ctl_mode = m;
    phase_cnt = 8'd0;
    for (int l = 0; l < 2; l++)
      if (d[a + l]) move_lane(t, a + l, saic_pkg::G_RED, saic_pkg::G_GREEN);
    return !(lane_is_red(t, a) && lane_is_red(t, a + 1));
  endfunction

  // Phases that light nothing fall through to the next one within the same tick.
  function automatic void close_phase(logic [3:0] sd, logic [3:0] rd);
    for (int k = 0; k < 4; k++) begin
      if (ctl_mode == saic_pkg::MODE_RIGHT) begin
        if (open_phase(saic_pkg::MODE_STRAIGHT, sd, rd)) return;
      end else if (ctl_mode == saic_pkg::MODE_STRAIGHT) begin
        early_straight = 2'b00;
        pair_sel = ~pair_sel;
        if (second_pair_due && pair_wants(pair_sel, sd, rd)) begin
          second_pair_due = 1'b0;
          if (open_phase(saic_pkg::MODE_RIGHT, sd, rd)) return;
        end else begin
          second_pair_due = 1'b0;
          ctl_mode = saic_pkg::MODE_DISPATCH;
          return;
        end
      end else begin
        return;
      end
    end
  endfunction

  function automatic void phase_step(logic [3:0] sd, logic [3:0] rd);
    int t;
    int a;
    int b;
    logic [3:0] d;
    logic [7:0] lim;
    t = (ctl_mode == saic_pkg::MODE_RIGHT) ? 1 : 0;
    d = t ? rd : sd;
    lim = t ? lim_right : lim_straight;
    a = pair_sel ? 2 : 0;
    b = a + 1;
    phase_cnt = bump(phase_cnt);
    for (int l = 0; l < 2; l++)
      if (lamp_lit(saic_pkg::G_YELLOW + t, a + l)) yel_cnt[l] = bump(yel_cnt[l]);
    for (int l = 0; l < 2; l++) begin
      if (lamp_lit(saic_pkg::G_GREEN + t, a + l) &&
          (!d[a + l] || timed_out(phase_cnt, lim))) begin
        move_lane(t, a + l, saic_pkg::G_GREEN, saic_pkg::G_YELLOW);
        yel_cnt[l] = 8'd0;
      end
    end
    for (int l = 0; l < 2; l++)
      if (lamp_lit(saic_pkg::G_YELLOW + t, a + l) && timed_out(yel_cnt[l], lim_yellow))
        move_lane(t, a + l, saic_pkg::G_YELLOW, saic_pkg::G_RED);
    // A straight lane may open early once the opposite right turn is red.
    if (t == 1) begin
      if (lane_is_red(1, b) && !early_straight[0] && sd[a]) begin
        early_straight[0] = 1'b1;
        move_lane(0, a, saic_pkg::G_RED, saic_pkg::G_GREEN);
      end
      if (lane_is_red(1, a) && !early_straight[1] && sd[b]) begin
        early_straight[1] = 1'b1;
        move_lane(0, b, saic_pkg::G_RED, saic_pkg::G_GREEN);
      end
    end
    if (lane_is_red(t, a) && lane_is_red(t, b)) close_phase(sd, rd);
  endfunction

  function automatic void dispatch_step(logic [3:0] sd, logic [3:0] rd);
    logic [3:0] any;
    int cnt;
    any = sd | rd;
    cnt = $countones(any);
    if (cnt == 0) begin
      if (!rest_green) begin
        move_lane(0, rest_side, saic_pkg::G_RED, saic_pkg::G_GREEN);
        rest_green = 1'b1;
      end
      return;
    end
    if (rest_green) begin
      move_lane(0, rest_side, saic_pkg::G_GREEN, saic_pkg::G_YELLOW);
      phase_cnt = 8'd0;
      ctl_mode = saic_pkg::MODE_IDLE_YELLOW;
      return;
    end
    if (cnt >= 3) begin
      second_pair_due = 1'b1;
    end else if (pair_wants(pair_sel, sd, rd)) begin
      second_pair_due = 1'b1;
    end else begin
      pair_sel = ~pair_sel;
      second_pair_due = 1'b0;
    end
    early_straight = 2'b00;
    if (!open_phase(saic_pkg::MODE_RIGHT, sd, rd)) close_phase(sd, rd);
  endfunction

  function automatic void idle_yellow_step();
    phase_cnt = bump(phase_cnt);
    if (timed_out(phase_cnt, lim_yellow)) begin
      move_lane(0, rest_side, saic_pkg::G_YELLOW, saic_pkg::G_RED);
      rest_green = 1'b0;
      picker = {picker[6:0], picker[7] ^ picker[5] ^ picker[4] ^ picker[3]};
      rest_side = picker[1:0];
      ctl_mode = saic_pkg::MODE_DISPATCH;
    end
  endfunction

  function automatic logic [23:0] advance_tick(logic [3:0] sd, logic [3:0] rd);
    case (ctl_mode)
      saic_pkg::MODE_RIGHT, saic_pkg::MODE_STRAIGHT: phase_step(sd, rd);
      saic_pkg::MODE_IDLE_YELLOW: idle_yellow_step();
      default: dispatch_step(sd, rd);
    endcase
    return lamps;
  endfunction

  // Driver: takes the next demand beat at the falling edge once the current one is gone.
  always @(posedge clk) begin
    beat_taken = !rst && s_axis_tvalid && s_axis_tready;
    if (beat_taken) begin
      lamp_expect.push_back(advance_tick(s_axis_tdata[3:0], s_axis_tdata[7:4]));
      beats_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || beat_taken) begin
      if (demand_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata <= demand_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, and every lamp beat checked against the oldest prediction.
  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    logic [23:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (lamp_expect.size() == 0) begin
        $error("lamp beat %06h arrived with no tick pending", m_axis_tdata);
        fail_count++;
      end else begin
        want = lamp_expect.pop_front();
        for (int g = 0; g < 6; g++) begin
          if (m_axis_tdata[4 * g +: 4] !== want[4 * g +: 4]) begin
            $error("%s: expected %h, got %h", lamp_field[g], want[4 * g +: 4],
                   m_axis_tdata[4 * g +: 4]);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic add_beat(logic [7:0] b);
    demand_q.push_back(b);
    beats_queued++;
  endtask

  // Mostly held demand patterns with the odd sensor flicker, some quiet spells and some noise.
  task automatic add_demand_runs(int n);
    int left;
    int kind;
    int len;
    logic [7:0] pat;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      pat = 8'h00;
      len = $urandom_range(1, 6);
      if (kind >= 2 && kind < 8) begin
        pat = 8'($urandom_range(1, 255));
        len = $urandom_range(2, 15);
      end else if (kind >= 8) begin
        len = $urandom_range(1, 4);
      end
      for (int k = 0; k < len && left > 0; k++) begin
        if (kind >= 8) pat = 8'($urandom_range(0, 255));
        else if (kind >= 2 && $urandom_range(0, 7) == 0) pat ^= 8'h01 << $urandom_range(0, 7);
        add_beat(pat);
        left--;
      end
    end
  endtask

  task automatic wait_drained();
    while (beats_taken != beats_queued || lamp_expect.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(logic [saic_pkg::CFG_INDEX_WIDTH-1:0] idx,
                         logic [saic_pkg::CFG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      saic_pkg::CFG_RIGHT_LIMIT: lim_right = val;
      saic_pkg::CFG_STRAIGHT_LIMIT: lim_straight = val;
      saic_pkg::CFG_YELLOW_TICKS: lim_yellow = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [7:0] r, logic [7:0] s, logic [7:0] y);
    set_reg(saic_pkg::CFG_RIGHT_LIMIT, r);
    set_reg(saic_pkg::CFG_STRAIGHT_LIMIT, s);
    set_reg(saic_pkg::CFG_YELLOW_TICKS, y);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset timing, sender idles a little and the receiver a lot.
    send_idle_pct = 10;
    recv_idle_pct = 54;
    // Quiet junction, then one straight sensor held past the limit.
    add_beat(8'h00);
    add_beat(8'h00);
    repeat (8) add_beat(8'h01);
    // A right-turn sensor alone.
    repeat (3) add_beat(8'h10);
    // Every sensor on, so both pairs get served.
    repeat (6) add_beat(8'hFF);
    add_beat(8'h0F);
    add_beat(8'hF0);
    // Straight of side three with right turn of side four, then quiet again.
    add_beat(8'h84);
    repeat (3) add_beat(8'h00);
    add_demand_runs(90);
    wait_drained();

    // Shortest limits.
    set_timing(8'd1, 8'd1, 8'd1);
    add_demand_runs(100);
    wait_drained();

    // Longest limits: a long all-demand stretch runs the phase counters into saturation.
    send_idle_pct = 54;
    recv_idle_pct = 10;
    set_timing(8'd255, 8'd255, 8'd255);
    set_reg(CFG_UNUSED_INDEX, 8'd3);
    repeat (270) add_beat(8'hFF);
    add_demand_runs(60);
    wait_drained();

    // Zero limits: greens drop on the first tick and yellow clears within its tick.
    set_timing(8'd0, 8'd0, 8'd0);
    add_demand_runs(90);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_timing(8'($urandom_range(2, 12)), 8'($urandom_range(2, 12)),
               8'($urandom_range(2, 12)));
    add_demand_runs(80);
    wait_drained();

    set_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
               8'($urandom_range(1, 20)));
    add_demand_runs(80);
    wait_drained();

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("sensor_actuated_intersection_controller_core regression: pass");
    end else begin
      $display("sensor_actuated_intersection_controller_core regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("sensor_actuated_intersection_controller_core regression: fail");
    $finish;
  end

endmodule
